@@ hdl/abl_pkg.sv @@
`default_nettype none

package abl_pkg;

    // Field and register widths
    localparam int LightW   = 12;
    localparam int CfgW     = 16;
    localparam int CntW     = 16;
    localparam int TargetW  = 18;
    localparam int SmoothW  = 24;
    localparam int LevelW   = 8;
    localparam int MulAW    = 24;
    localparam int MulBW    = 16;
    localparam int ProdW    = MulAW + MulBW;
    localparam int AccW     = 36;
    localparam int SumW     = ProdW + 1;
    localparam int AddrW    = 4;

    // Register map (word index = paddr[3:2])
    localparam logic [1:0] REG_GAIN    = 2'd0;
    localparam logic [1:0] REG_OFFSET  = 2'd1;
    localparam int          RegIdxLo   = 2;

    localparam logic [1:0] REG_TIMEOUT = 2'd2;

    // Reset values
    localparam logic [CfgW-1:0]    GAIN_RST    = 16'd333;
    localparam logic [CfgW-1:0]    OFFSET_RST  = 16'd1280;
    localparam logic [CfgW-1:0]    TIMEOUT_RST = 16'd600;
    localparam logic [SmoothW-1:0] SMOOTH_RST  = 24'd327680;

    // Filter constants: target clamp 512.0 in Q10.8, level clamp 255.0 in Q8.16
    localparam logic [TargetW-1:0] TARGET_MAX = 18'd131072;
    localparam logic [SmoothW-1:0] SMOOTH_MAX = 24'hFF0000;
    localparam logic [MulBW-1:0]   W_NEW      = 16'd655;
    localparam logic [MulBW-1:0]   W_OLD      = 16'd64881;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_GAIN,
        ST_TARGET,
        ST_MUL_NEW,
        ST_MUL_OLD,
        ST_ACCUM,
        ST_ISSUE
    } abl_state_t;

    typedef struct packed {
        logic accept;
        logic mul_gain;
        logic target;
        logic mul_new;
        logic mul_old;
        logic accum;
        logic issue;
    } abl_cmd_t;

    typedef struct packed {
        logic awake;
        logic out_free;
    } abl_stat_t;

    typedef struct packed {
        logic [CfgW-1:0] gain;
        logic [CfgW-1:0] offset;
        logic [CfgW-1:0] timeout;
    } abl_cfg_t;

endpackage

`default_nettype wire

@@ hdl/abl_cfg.sv @@
`default_nettype none

module abl_cfg
    import abl_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [AddrW-1:0] paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output logic                  pready,
    output abl_cfg_t              cfg
);

    logic [CfgW-1:0] gain_reg;
    logic [CfgW-1:0] offset_reg;
    logic [CfgW-1:0] timeout_reg;
    logic [1:0]      idx;
    logic            wr_en;

    assign idx    = paddr[AddrW-1:RegIdxLo];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Write registers on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg    <= GAIN_RST;
            offset_reg  <= OFFSET_RST;
            timeout_reg <= TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            if (idx == REG_GAIN)
            begin
                gain_reg <= pwdata[CfgW-1:0];
            end
            if (idx == REG_OFFSET)
            begin
                offset_reg <= pwdata[CfgW-1:0];
            end
            if (idx == REG_TIMEOUT)
            begin
                timeout_reg <= pwdata[CfgW-1:0];
            end
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        if (idx == REG_GAIN)
        begin
            prdata = {16'd0, gain_reg};
        end
        else if (idx == REG_OFFSET)
        begin
            prdata = {16'd0, offset_reg};
        end
        else if (idx == REG_TIMEOUT)
        begin
            prdata = {16'd0, timeout_reg};
        end
    end

    assign cfg.gain    = gain_reg;
    assign cfg.offset  = offset_reg;
    assign cfg.timeout = timeout_reg;

endmodule

`default_nettype wire

@@ hdl/abl_dp.sv @@
`default_nettype none

module abl_dp
    import abl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire abl_cfg_t    cfg,
    input  wire abl_cmd_t    cmd,
    output abl_stat_t        stat,
    input  wire logic [15:0] in_word,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      out_word
);

    logic [LightW-1:0]  light_reg;
    logic               awake_reg, awake_next;
    logic               fell_reg, fell_next;
    logic [CntW-1:0]    cnt_reg, cnt_next;
    logic [SmoothW-1:0] smooth_reg, smooth_next;
    logic [LevelW-1:0]  last_reg;
    logic               last_valid_reg;
    logic [TargetW-1:0] target_reg, target_next;
    logic [ProdW-1:0]   prod_reg;
    logic [AccW-1:0]    acc_reg;
    logic               out_valid_reg;
    logic [15:0]        out_word_reg;

    logic               wake;
    logic [CntW-1:0]    cnt_in;
    logic               awake_mid;
    logic [MulAW-1:0]   mul_a;
    logic [MulBW-1:0]   mul_b;
    logic [28:0]        tgt_sum;
    logic [SumW-1:0]    total;
    logic [24:0]        shifted;
    logic [LevelW-1:0]  level_cand;
    logic               do_issue;

    // Wake and timeout update for the incoming word
    always_comb
    begin
        wake      = in_word[12] || in_word[13] || in_word[14];
        cnt_in    = wake ? cfg.timeout : cnt_reg;
        awake_mid = wake || awake_reg;
        if (cnt_in != '0)
        begin
            cnt_next   = cnt_in - 1'b1;
            awake_next = awake_mid;
            fell_next  = 1'b0;
        end
        else
        begin
            cnt_next   = cnt_in;
            awake_next = 1'b0;
            fell_next  = awake_mid;
        end
    end

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = {{(MulAW-LightW){1'b0}}, light_reg};
        mul_b = cfg.gain;
        if (cmd.mul_new)
        begin
            mul_a = {{(MulAW-TargetW){1'b0}}, target_reg};
            mul_b = W_NEW;
        end
        else if (cmd.mul_old)
        begin
            mul_a = smooth_reg;
            mul_b = W_OLD;
        end
    end

    // Target clamp and filter sum
    always_comb
    begin
        tgt_sum     = prod_reg[28:0] + {13'd0, cfg.offset};
        target_next = (tgt_sum > {11'd0, TARGET_MAX}) ? TARGET_MAX : tgt_sum[TargetW-1:0];
        total       = {{(SumW-AccW){1'b0}}, acc_reg} + {1'b0, prod_reg};
        shifted     = total[SumW-1:16];
        smooth_next = (shifted > {1'b0, SMOOTH_MAX}) ? SMOOTH_MAX : shifted[SmoothW-1:0];
    end

    // Level issue decision
    always_comb
    begin
        level_cand = awake_reg ? smooth_reg[SmoothW-1:SmoothW-LevelW] : '0;
        do_issue   = (awake_reg || fell_reg) && (!last_valid_reg || (last_reg != level_cand));
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            light_reg <= in_word[LightW-1:0];
        end
        if (cmd.mul_gain || cmd.mul_new || cmd.mul_old)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.target)
        begin
            target_reg <= target_next;
        end
        if (cmd.mul_old)
        begin
            acc_reg <= {prod_reg[27:0], 8'd0};
        end
        if (cmd.issue)
        begin
            out_word_reg <= {6'd0, (do_issue ? level_cand : 8'd0), do_issue, awake_reg};
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awake_reg      <= 1'b1;
            fell_reg       <= 1'b0;
            cnt_reg        <= TIMEOUT_RST;
            smooth_reg     <= SMOOTH_RST;
            last_reg       <= '0;
            last_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                awake_reg <= awake_next;
                fell_reg  <= fell_next;
                cnt_reg   <= cnt_next;
            end
            if (cmd.accum)
            begin
                smooth_reg <= smooth_next;
            end
            if (cmd.issue && do_issue)
            begin
                last_reg       <= level_cand;
                last_valid_reg <= 1'b1;
            end
            // Hold the word until taken
            if (cmd.issue)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.awake    = awake_reg;
    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_word      = out_word_reg;

endmodule

`default_nettype wire

@@ hdl/abl_ctrl.sv @@
`default_nettype none

module abl_ctrl
    import abl_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire abl_stat_t stat,
    output abl_cmd_t       cmd
);

    abl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence one tick through the shared multiplier
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ST_MUL_GAIN;
                end
            end
            ST_MUL_GAIN:
            begin
                cmd.mul_gain = 1'b1;
                state_next   = stat.awake ? ST_TARGET : ST_ISSUE;
            end
            ST_TARGET:
            begin
                cmd.target = 1'b1;
                state_next = ST_MUL_NEW;
            end
            ST_MUL_NEW:
            begin
                cmd.mul_new = 1'b1;
                state_next  = ST_MUL_OLD;
            end
            ST_MUL_OLD:
            begin
                cmd.mul_old = 1'b1;
                state_next  = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                if (stat.out_free)
                begin
                    cmd.issue  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/auto_backlight_with_sleep_timeout.sv @@
// Ambient-light auto brightness with a display sleep timeout.
// Input stream: one word per display frame on s_tvalid/s_tready/s_tdata,
// carrying the light sample and the touch, engine and ignition flags.
// Output stream: exactly one word per input word on m_tvalid/m_tready/m_tdata,
// giving the display power state and, when flagged, a new backlight level.
// Registers for gain, offset and wake timeout sit on the APB port at 0x0,
// 0x4 and 0x8; write them only while no word is in flight.
// Steps per word while awake: accept, product of light and gain, target
// clamp, two filter products and the sum, issue; while asleep: accept, the
// product of light and gain, issue. All products share one 24x16 multiplier,
// and a new input word is accepted only once the last one has been issued,
// so one word is in the steps at a time.
// A finished word waits in the output register; the next input word is
// accepted meanwhile, and its own issue step holds until the register frees.
// Reset brings registers to their defaults, the display awake with a full
// timeout and the filter at the offset level, with no level yet issued.
`default_nettype none

module auto_backlight_with_sleep_timeout
    import abl_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // APB configuration
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [AddrW-1:0] paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output logic                  pready,
    // Input stream
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [15:0]      s_tdata,  // light_level[11:0], touched, engine_started,
                                            // ignition_on, zero pad
    // Output stream
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic      [15:0]      m_tdata   // display_on, level_write, level_value[7:0],
                                            // zero pad
);

    abl_cfg_t  cfg;
    abl_cmd_t  cmd;
    abl_stat_t stat;

    abl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    abl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    abl_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .stat      (stat),
        .in_word   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (m_tdata)
    );

endmodule

`default_nettype wire
